[rtl/dad_pkg.sv]
// shared types, constants and month table for the date add days block
`timescale 1ns / 1ps

package dad_pkg;

  // field widths
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DaysW  = 20;
  localparam int unsigned QuotW  = 10;
  localparam int unsigned Mod25W = 5;

  // year limits and constants
  localparam logic [YearW-1:0]  YearMax  = 14'd16383;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [Mod25W-1:0] Mod25Top = 5'd24;

  // reciprocal of 25 scaled by 2^19, rounded up; exact for all 14-bit years
  localparam logic [14:0] Recip25   = 15'd20972;
  localparam int unsigned Recip25Sh = 19;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_CLAMP,
    ST_WALK,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic clamp;
    logic step;
    logic out_load;
  } dad_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rem_zero;
  } dad_sts_t;

  // days in a month of a common year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/date_add_days_core.sv]
// Gregorian date plus a day count: usage overview below.
// Input stream carries one start date and a day count per item; output
// stream returns the advanced date and a year overflow flag per item.
// An accepted item passes through the setup steps (year mod 25 through a
// reciprocal multiply, remainder, day clamp), then the month walk, which
// consumes one month per cycle, then a load of the output register. The
// month walk sets the rate: a new item is taken only after the last one is
// loaded into the output register, and the walk crosses up to about 34,500
// month boundaries for the largest day count.
// One item is in work at a time; s_axis_tready_o is high only while idle.
// The output register holds a finished result while the receiver stalls,
// and the next item may be taken and walked meanwhile; it waits for the
// register to free before delivery.
// Reset clears the controller and the output valid; no item is held.
// Year overflow: past year 16383 the year saturates and the flag is set.
`timescale 1ns / 1ps

module date_add_days_core import dad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // month_in[3:0], day_in[8:4], year_in[22:9], days_to_add[42:23], zero pad
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // month_out[3:0], day_out[8:4], year_out[22:9], year_overflow[23]
  output logic [23:0] m_axis_tdata_o
);

  dad_cmd_t          cmd;
  dad_sts_t          sts;
  logic [MonthW-1:0] month_out;
  logic [DayW-1:0]   day_out;
  logic [YearW-1:0]  year_out;
  logic              ovf_out;

  // controller
  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  dad_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .month_in_i  (s_axis_tdata_i[3:0]),
    .day_in_i    (s_axis_tdata_i[8:4]),
    .year_in_i   (s_axis_tdata_i[22:9]),
    .days_in_i   (s_axis_tdata_i[42:23]),
    .month_out_o (month_out),
    .day_out_o   (day_out),
    .year_out_o  (year_out),
    .ovf_out_o   (ovf_out)
  );

  // output packing
  assign m_axis_tdata_o = {ovf_out, year_out, day_out, month_out};

`ifndef SYNTHESIS
  // an accepted item closes the input until it is handed to the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  // delivered month is always a real month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[3:0] != 4'd0) && (m_axis_tdata_o[3:0] <= MonthDec)))
    else $error("month out of range");

  // delivered day is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[8:4] != 5'd0))
    else $error("day out is zero");

  // overflow only with a saturated year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[23]) |-> (m_axis_tdata_o[22:9] == YearMax))
    else $error("overflow without saturated year");
`endif

endmodule

[rtl/dad_ctrl.sv]
// controller state machine: input handshake, walk sequencing, output valid
`timescale 1ns / 1ps

module dad_ctrl import dad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dad_sts_t sts_i,
  output dad_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.rem_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        // hand the item to the output register once it is free
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid follows loads and takes
  always_comb begin
    valid_d = valid_q;
    priority if (cmd_o.out_load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[rtl/dad_dp.sv]
// datapath: date registers, year mod 25 tracking, month step and output register
`timescale 1ns / 1ps

module dad_dp import dad_pkg::*; (
  input  logic              clk_i,
  input  dad_cmd_t          cmd_i,
  output dad_sts_t          sts_o,
  input  logic [MonthW-1:0] month_in_i,
  input  logic [DayW-1:0]   day_in_i,
  input  logic [YearW-1:0]  year_in_i,
  input  logic [DaysW-1:0]  days_in_i,
  output logic [MonthW-1:0] month_out_o,
  output logic [DayW-1:0]   day_out_o,
  output logic [YearW-1:0]  year_out_o,
  output logic              ovf_out_o
);

  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [DaysW-1:0]  rem_q, rem_d;
  logic              ovf_q, ovf_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  logic [Mod25W-1:0] mod25_q, mod25_d;

  logic [MonthW-1:0] month_o_q;
  logic [DayW-1:0]   day_o_q;
  logic [YearW-1:0]  year_o_q;
  logic              ovf_o_q;

  logic [28:0]       prod;
  logic [YearW-1:0]  quot25;
  logic [YearW-1:0]  diff25;
  logic              leap;
  logic [DayW-1:0]   len;
  logic [DayW-1:0]   left;
  logic [DaysW-1:0]  left_ext;

  // quotient of year by 25 through the scaled reciprocal
  assign prod   = {15'd0, year_q} * {14'd0, Recip25};
  assign quot25 = ({4'd0, quot_q} << 4) + ({4'd0, quot_q} << 3) + {4'd0, quot_q};
  assign diff25 = year_q - quot25;

  // leap year from low year bits and the year mod 25
  assign leap = (year_q[1:0] == 2'd0) && ((mod25_q != '0) || (year_q[3:0] == 4'd0));
  assign len  = month_len(month_q) + {4'd0, (month_q == MonthFeb) && leap};
  assign left = len - day_q;
  assign left_ext = {{(DaysW-DayW){1'b0}}, left};

  // working registers
  always_comb begin
    month_d = month_q;
    day_d   = day_q;
    year_d  = year_q;
    rem_d   = rem_q;
    ovf_d   = ovf_q;
    quot_d  = quot_q;
    mod25_d = mod25_q;
    priority if (cmd_i.load) begin
      month_d = ((month_in_i == '0) || (month_in_i > MonthDec)) ? MonthJan : month_in_i;
      day_d   = (day_in_i == '0) ? DayFirst : day_in_i;
      year_d  = year_in_i;
      rem_d   = days_in_i;
      ovf_d   = 1'b0;
    end else if (cmd_i.div) begin
      quot_d = prod[28:Recip25Sh];
    end else if (cmd_i.rem) begin
      mod25_d = diff25[Mod25W-1:0];
    end else if (cmd_i.clamp) begin
      if (day_q > len) begin
        day_d = len;
      end
    end else if (cmd_i.step) begin
      if (rem_q > left_ext) begin
        // finish this month and move to the first of the next
        rem_d = rem_q - left_ext - {{(DaysW-1){1'b0}}, 1'b1};
        day_d = DayFirst;
        if (month_q == MonthDec) begin
          month_d = MonthJan;
          if (year_q == YearMax) begin
            ovf_d = 1'b1;
          end else begin
            year_d  = year_q + {{(YearW-1){1'b0}}, 1'b1};
            mod25_d = (mod25_q == Mod25Top) ? '0 : mod25_q + {{(Mod25W-1){1'b0}}, 1'b1};
          end
        end else begin
          month_d = month_q + {{(MonthW-1){1'b0}}, 1'b1};
        end
      end else begin
        // remaining days fit in this month
        day_d = day_q + rem_q[DayW-1:0];
        rem_d = '0;
      end
    end else begin
      // no command: working registers hold
    end
  end

  always_ff @(posedge clk_i) begin
    month_q <= month_d;
    day_q   <= day_d;
    year_q  <= year_d;
    rem_q   <= rem_d;
    ovf_q   <= ovf_d;
    quot_q  <= quot_d;
    mod25_q <= mod25_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      month_o_q <= month_q;
      day_o_q   <= day_q;
      year_o_q  <= year_q;
      ovf_o_q   <= ovf_q;
    end
  end

  assign sts_o.rem_zero = (rem_q == '0);
  assign month_out_o    = month_o_q;
  assign day_out_o      = day_o_q;
  assign year_out_o     = year_o_q;
  assign ovf_out_o      = ovf_o_q;

endmodule

[dv/date_add_days_core_tb.sv]
// testbench for date_add_days_core: random and corner dates checked against a predictor
`timescale 1ns / 1ps

module date_add_days_core_tb;
  import dad_pkg::*;

  // one advanced date as the block should return it
  typedef struct {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic              ovf;
  } date_t;

  // predictor plus queue of dates still owed by the block
  class date_scoreboard;
    date_t       owed_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned days_in(logic [MonthW-1:0] m, int unsigned y);
      int unsigned n;
      case (m)
        MonthFeb:                n = is_leap(y) ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11: n = 30;
        default:                 n = 31;
      endcase
      return n;
    endfunction

    // walk forward one month at a time
    function date_t advance(logic [MonthW-1:0] m_in, logic [DayW-1:0] d_in,
                            logic [YearW-1:0] y_in, logic [DaysW-1:0] count);
      date_t       r;
      int unsigned m, d, y, rem, len, left;
      m = (m_in >= MonthJan && m_in <= MonthDec) ? m_in : MonthJan;
      d = (d_in == 0) ? 1 : d_in;
      y = y_in;
      rem = count;
      r.ovf = 1'b0;
      len = days_in(MonthW'(m), y);
      if (d > len) d = len;
      while (rem > 0) begin
        len = days_in(MonthW'(m), y);
        left = len - d;
        if (rem > left) begin
          rem -= left + 1;
          d = 1;
          if (m == MonthDec) begin
            m = MonthJan;
            if (y >= YearMax) begin
              y = YearMax;
              r.ovf = 1'b1;
            end else begin
              y++;
            end
          end else begin
            m++;
          end
        end else begin
          d += rem;
          rem = 0;
        end
      end
      r.month = MonthW'(m);
      r.day = DayW'(d);
      r.year = YearW'(y);
      return r;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_input(logic [47:0] data);
      owed_q.push_back(advance(data[3:0], data[8:4], data[22:9], data[42:23]));
    endfunction

    task check_result(logic [23:0] data);
      date_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result %h with no date pending", data));
        return;
      end
      want = owed_q.pop_front();
      if (data[3:0] !== want.month)
        report($sformatf("month %0d, want %0d", data[3:0], want.month));
      if (data[8:4] !== want.day)
        report($sformatf("day %0d, want %0d", data[8:4], want.day));
      if (data[22:9] !== want.year)
        report($sformatf("year %0d, want %0d", data[22:9], want.year));
      if (data[23] !== want.ovf)
        report($sformatf("overflow %0b, want %0b", data[23], want.ovf));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;

  date_scoreboard sb;
  logic           hold_req;
  int             burst_left;

  date_add_days_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // offer one item and wait for it to be taken
  task automatic send_date(logic [MonthW-1:0] m, logic [DayW-1:0] d,
                           logic [YearW-1:0] y, logic [DaysW-1:0] count);
    logic [47:0] data;
    data = {5'b0, count, y, d, m};
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(data);
  endtask

  // bursts with random gaps in between
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = 40;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // random date with mostly short day counts
  task automatic send_random(bit short_only);
    logic [MonthW-1:0] m;
    logic [DayW-1:0]   d;
    logic [YearW-1:0]  y;
    logic [DaysW-1:0]  count;
    int unsigned       pick;
    m = ($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1) == 0) ? 4'd0 :
        4'($urandom_range(13, 15))) : 4'($urandom_range(1, 12));
    d = ($urandom_range(0, 29) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    pick = $urandom_range(0, 9);
    if (pick == 0) y = 14'($urandom_range(16370, 16383));
    else if (pick == 1) y = 14'($urandom_range(0, 40) * 100);
    else y = 14'($urandom_range(0, 16383));
    pick = $urandom_range(0, 99);
    if (short_only || pick < 80) count = 20'($urandom_range(0, 400));
    else if (pick < 98) count = 20'($urandom_range(0, 20000));
    else count = 20'($urandom_range(0, 1048575));
    send_date(m, d, y, count);
    pace_sender();
  endtask

  // receiver: changing stall pattern plus one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned hold_cnt;
    bit          held;
    cyc = 0;
    hold_cnt = 0;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      cyc++;
      if (hold_req && !held) begin
        hold_cnt++;
        if (hold_cnt >= 500) held = 1'b1;
        m_axis_tready_i <= 1'b0;
      end else begin
        case ((cyc / 256) % 4)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= (cyc % 5 == 0);
          default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    hold_req = 1'b0;
    burst_left = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner dates
    send_date(4'd1, 5'd1, 14'd2000, 20'd0);
    send_date(4'd12, 5'd31, 14'd1999, 20'd1);
    send_date(4'd2, 5'd28, 14'd2000, 20'd1);
    send_date(4'd2, 5'd28, 14'd1900, 20'd1);
    send_date(4'd2, 5'd29, 14'd2024, 20'd365);
    send_date(4'd2, 5'd31, 14'd2023, 20'd0);
    send_date(4'd4, 5'd31, 14'd2023, 20'd1);
    send_date(4'd0, 5'd15, 14'd2021, 20'd10);
    send_date(4'd13, 5'd10, 14'd1984, 20'd40);
    send_date(4'd15, 5'd31, 14'd0, 20'd59);
    send_date(4'd6, 5'd0, 14'd2022, 20'd5);
    send_date(4'd12, 5'd31, 14'd16383, 20'd1);
    send_date(4'd12, 5'd31, 14'd16383, 20'd0);
    send_date(4'd11, 5'd30, 14'd16382, 20'd400);
    send_date(4'd2, 5'd29, 14'd2100, 20'd1);
    send_date(4'd2, 5'd28, 14'd2400, 20'd1);
    send_date(4'd14, 5'd31, 14'd16383, 20'd31);
    send_date(4'd7, 5'd31, 14'd1600, 20'd146097);
    send_date(4'd5, 5'd15, 14'd8191, 20'hAAAAA);
    send_date(4'd10, 5'd5, 14'd5461, 20'h55555);
    send_date(4'd1, 5'd1, 14'd0, 20'hFFFFF);
    send_date(4'd12, 5'd31, 14'd16383, 20'hFFFFF);

    // random dates; the receiver holds off while the first ones are offered
    hold_req <= 1'b1;
    for (int i = 0; i < 500; i++) send_random(i < 40);
    s_axis_tvalid_i <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[date_add_days_core.f]
rtl/dad_pkg.sv
rtl/dad_ctrl.sv
rtl/dad_dp.sv
rtl/date_add_days_core.sv
dv/date_add_days_core_tb.sv
